// File: rtl/uipc_pkg.sv
// shared types and constants for the interval union point counter
package uipc_pkg;

  localparam int unsigned HALF_W = 32;
  localparam int unsigned ENTRY_W = 2 * HALF_W;
  localparam int unsigned TOTAL_W = HALF_W + 1;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic merge_step;
    logic sweep_init;
    logic sweep_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sort_done;
    logic sweep_done;
  } status_t;

endpackage

// File: rtl/uipc_ram.sv
// generic ram, one write port and two registered read ports
module uipc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/uipc_ctrl.sv
// controller: load, merge passes, sweep and result sequencing
module uipc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_interval,
  input  uipc_pkg::status_t status,
  output uipc_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [2:0] {
    S_IDLE, S_SORT_RD, S_SORT_WR, S_SWEEP_RD, S_SWEEP_ACC, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_interval) begin
            cmd.sort_init = 1'b1;
            state_next = S_SORT_RD;
          end
        end
      end
      S_SORT_RD: begin
        if (status.sort_done) begin
          cmd.sweep_init = 1'b1;
          state_next = S_SWEEP_RD;
        end else begin
          state_next = S_SORT_WR;
        end
      end
      S_SORT_WR: begin
        cmd.merge_step = 1'b1;
        state_next = S_SORT_RD;
      end
      S_SWEEP_RD: begin
        state_next = status.sweep_done ? S_DONE : S_SWEEP_ACC;
      end
      S_SWEEP_ACC: begin
        cmd.sweep_step = 1'b1;
        state_next = S_SWEEP_RD;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_DONE);
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last_interval |=> !busy)
    else $error("non-final item left the block busy");

endmodule

// File: rtl/uipc_dp.sv
// datapath: interval stores, merge counters and union sweep
module uipc_dp #(
  parameter int unsigned MAX_INTERVALS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  uipc_pkg::cmd_t                cmd,
  output uipc_pkg::status_t             status,
  input  logic signed [31:0]            interval_begin,
  input  logic signed [31:0]            interval_end,
  output logic [uipc_pkg::TOTAL_W-1:0]  covered_points,
  output logic                          overflow
);

  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned PW = CW + 1;
  localparam int unsigned HW = uipc_pkg::HALF_W;
  localparam int unsigned EW = uipc_pkg::ENTRY_W;
  localparam int unsigned TW = uipc_pkg::TOTAL_W;

  logic [CW-1:0] count;
  logic          ovf_seen;
  logic [PW-1:0] width;
  logic [PW-1:0] lo;
  logic [PW-1:0] ia;
  logic [PW-1:0] ib;
  logic [PW-1:0] k;
  logic          sel;
  logic [CW-1:0] idx;
  logic          first;
  logic          sweeping;
  logic [HW-1:0] run_start;
  logic [HW-1:0] run_fin;
  logic [TW-1:0] total;

  // offset by half range so unsigned order matches signed order
  logic [HW-1:0] ob;
  logic [HW-1:0] oe;
  assign ob = {~interval_begin[HW-1], interval_begin[HW-2:0]};
  assign oe = {~interval_end[HW-1], interval_end[HW-2:0]};

  logic [PW-1:0] n_ext;
  logic [PW-1:0] mid;
  logic [PW-1:0] hi;
  logic [PW-1:0] lo_w;
  logic [PW-1:0] lo_2w;
  assign n_ext = PW'(count);
  assign lo_w  = lo + width;
  assign lo_2w = lo + (width << 1);
  assign mid   = (lo_w > n_ext) ? n_ext : lo_w;
  assign hi    = (lo_2w > n_ext) ? n_ext : lo_2w;

  assign status.sort_done  = (width >= n_ext);
  assign status.sweep_done = (idx == count);

  // ram ports
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          we0;
  logic          we1;
  logic [EW-1:0] d0a, d0b, d1a, d1b;
  logic [EW-1:0] da, db;
  logic          take_b;
  logic          load_ok;

  assign load_ok = cmd.load && (ob <= oe) && (count < CW'(MAX_INTERVALS));
  assign ra = sweeping ? idx[AW-1:0] : ia[AW-1:0];
  assign rb = ib[AW-1:0];
  assign da = sel ? d1a : d0a;
  assign db = sel ? d1b : d0b;
  assign take_b = (ia >= mid) || ((ib < hi) && (db[EW-1:HW] < da[EW-1:HW]));

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    waddr = k[AW-1:0];
    wdata = take_b ? db : da;
    if (cmd.load) begin
      we0 = load_ok;
      waddr = count[AW-1:0];
      wdata = {ob, oe};
    end else if (cmd.merge_step) begin
      we0 = sel;
      we1 = !sel;
    end
  end

  uipc_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_ram0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(d0a), .rdata_b(d0b)
  );

  uipc_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_ram1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(d1a), .rdata_b(d1b)
  );

  logic [PW-1:0] k1;
  logic [PW-1:0] w2;
  assign k1 = k + PW'(1);
  assign w2 = width << 1;

  logic [HW-1:0] eb;
  logic [HW-1:0] ee;
  assign eb = da[EW-1:HW];
  assign ee = da[HW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf_seen <= 1'b0;
      sel <= 1'b0;
      first <= 1'b0;
      sweeping <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (load_ok) begin
          count <= count + CW'(1);
        end else if (ob <= oe) begin
          ovf_seen <= 1'b1;
        end
      end
      if (cmd.sort_init) begin
        sel <= 1'b0;
        sweeping <= 1'b0;
      end
      if (cmd.merge_step && k1 == hi && lo_2w >= n_ext) begin
        sel <= ~sel;
      end
      // sweep reads walk idx, sort reads walk ia and ib
      if (cmd.sweep_init) begin
        first <= 1'b1;
        sweeping <= 1'b1;
      end
      if (cmd.sweep_step) begin
        first <= 1'b0;
      end
      if (cmd.finish) begin
        count <= '0;
        ovf_seen <= 1'b0;
        sweeping <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      width <= PW'(1);
      lo <= '0;
      ia <= '0;
      ib <= PW'(1);
      k <= '0;
    end else if (cmd.merge_step) begin
      if (k1 == hi) begin
        if (lo_2w >= n_ext) begin
          width <= w2;
          lo <= '0;
          ia <= '0;
          ib <= w2;
          k <= '0;
        end else begin
          lo <= lo_2w;
          ia <= lo_2w;
          ib <= lo_2w + width;
          k <= lo_2w;
        end
      end else begin
        k <= k1;
        if (take_b) begin
          ib <= ib + PW'(1);
        end else begin
          ia <= ia + PW'(1);
        end
      end
    end
    if (cmd.sweep_init) begin
      idx <= '0;
      total <= '0;
    end
    if (cmd.sweep_step) begin
      idx <= idx + CW'(1);
      if (first) begin
        run_start <= eb;
        run_fin <= ee;
      end else if (eb > run_fin) begin
        total <= total + TW'(run_fin - run_start) + TW'(1);
        run_start <= eb;
        run_fin <= ee;
      end else if (ee > run_fin) begin
        run_fin <= ee;
      end
    end
    if (cmd.finish) begin
      covered_points <= (count == '0) ? '0
                        : total + TW'(run_fin - run_start) + TW'(1);
      overflow <= ovf_seen;
    end
  end

endmodule

// File: rtl/interval_union_point_count.sv
// top level of the interval union point counter
// Intervals are loaded one item per cycle while busy is low; an inverted
// interval is ignored and one beyond MAX_INTERVALS is dropped and flags
// overflow. The item with last_interval high closes the set: busy rises,
// the stored n intervals are merge sorted bottom-up in about ceil(log2(n))
// passes, each entry taking a read state and a write state through the
// registered read of the ping-pong stores, then swept with a read state and
// an accumulate state per entry. The result appears for one cycle with done,
// and busy is low again from that cycle on; the receiver must take it then,
// as there is no back-pressure.
module interval_union_point_count #(
  parameter int unsigned MAX_INTERVALS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           interval_begin,
  input  logic signed [31:0]           interval_end,
  input  logic                         last_interval,
  output logic                         done,
  output logic [uipc_pkg::TOTAL_W-1:0] covered_points,
  output logic                         overflow
);

  uipc_pkg::cmd_t    cmd;
  uipc_pkg::status_t status;

  uipc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_interval(last_interval),
    .status(status), .cmd(cmd), .busy(busy), .done(done)
  );

  uipc_dp #(.MAX_INTERVALS(MAX_INTERVALS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .interval_begin(interval_begin), .interval_end(interval_end),
    .covered_points(covered_points), .overflow(overflow)
  );

endmodule

// File: test/interval_union_point_count_tb.sv
// testbench for the interval union point counter: directed, capacity and random sets
`timescale 1ns / 100ps

module interval_union_point_count_tb;

  localparam int unsigned CAP = 1024;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam longint MIN_POINT = -64'sd2147483648;
  localparam longint MAX_POINT = 64'sd2147483647;

  typedef struct {
    logic [uipc_pkg::TOTAL_W-1:0] points;
    logic                         ovf;
  } union_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic signed [31:0]           interval_begin = '0;
  logic signed [31:0]           interval_end = '0;
  logic                         last_interval = 1'b0;
  logic                         busy;
  logic                         done;
  logic [uipc_pkg::TOTAL_W-1:0] covered_points;
  logic                         overflow;

  union_result_t             union_expect_q[$];
  longint                    held_begin[CAP];
  longint                    held_end[CAP];
  int unsigned               held_count;
  bit                        held_overflow;
  int unsigned               mismatches;
  int unsigned               results_seen;
  int unsigned               sets_sent;
  int unsigned               items_sent;
  bit                        no_gaps;
  longint unsigned           cycle_count;

  interval_union_point_count #(.MAX_INTERVALS(CAP)) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .interval_begin(interval_begin),
    .interval_end(interval_end),
    .last_interval(last_interval),
    .done(done),
    .covered_points(covered_points),
    .overflow(overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // sort the held intervals by begin, then sweep for the union size
  function automatic logic [uipc_pkg::TOTAL_W-1:0] union_size();
    longint sb[CAP];
    longint se[CAP];
    longint kb, ke, run_start, run_finish, total;
    int j;
    for (int i = 0; i < held_count; i++) begin
      kb = held_begin[i];
      ke = held_end[i];
      j = i - 1;
      while (j >= 0 && sb[j] > kb) begin
        sb[j+1] = sb[j];
        se[j+1] = se[j];
        j--;
      end
      sb[j+1] = kb;
      se[j+1] = ke;
    end
    if (held_count == 0) return '0;
    total = 0;
    run_start = sb[0];
    run_finish = se[0];
    for (int i = 1; i < held_count; i++) begin
      if (sb[i] > run_finish) begin
        total += run_finish - run_start + 1;
        run_start = sb[i];
        run_finish = se[i];
      end else if (se[i] > run_finish) begin
        run_finish = se[i];
      end
    end
    total += run_finish - run_start + 1;
    return total[uipc_pkg::TOTAL_W-1:0];
  endfunction

  task automatic predict_interval(input logic signed [31:0] b, input logic signed [31:0] e,
                                  input bit last);
    union_result_t r;
    if (b <= e) begin
      if (held_count < CAP) begin
        held_begin[held_count] = b;
        held_end[held_count] = e;
        held_count++;
      end else begin
        held_overflow = 1'b1;
      end
    end
    if (last) begin
      r.points = union_size();
      r.ovf = held_overflow;
      union_expect_q.push_back(r);
      held_count = 0;
      held_overflow = 1'b0;
      sets_sent++;
    end
  endtask

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance and any random idle gap
  task automatic send_interval(input logic signed [31:0] b, input logic signed [31:0] e,
                               input bit last);
    int gap;
    interval_begin = b;
    interval_end = e;
    last_interval = last;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_interval(b, e, last);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      interval_begin = $urandom;
      interval_end = $urandom;
      last_interval = $urandom_range(0, 1);
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    union_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (union_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: points %0d overflow %0b", covered_points, overflow);
      end else begin
        want = union_expect_q.pop_front();
        if (covered_points !== want.points || overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("set %0d: expected points %0d overflow %0b, got points %0d overflow %0b",
                     results_seen, want.points, want.ovf, covered_points, overflow);
        end
      end
    end
  end

  task automatic test_directed();
    send_interval(32'(MIN_POINT), 32'(MAX_POINT), 1'b1);
    send_interval(5, 3, 1'b1);
    send_interval(7, 7, 1'b0);
    send_interval(9, 2, 1'b1);
    send_interval(0, 5, 1'b0);
    send_interval(6, 9, 1'b0);
    send_interval(20, 30, 1'b0);
    send_interval(-10, 25, 1'b0);
    send_interval(22, 24, 1'b0);
    send_interval(22, 24, 1'b1);
    send_interval(32'(MAX_POINT), 32'(MAX_POINT), 1'b0);
    send_interval(32'(MIN_POINT), 32'(MIN_POINT), 1'b0);
    send_interval(32'(MAX_POINT), 32'(MIN_POINT), 1'b0);
    send_interval(-1, 0, 1'b1);
    send_interval(100, 200, 1'b0);
    send_interval(32'(MIN_POINT), -1, 1'b0);
    send_interval(0, 32'(MAX_POINT), 1'b1);
    send_interval(40, 50, 1'b0);
    send_interval(50, 60, 1'b0);
    send_interval(-5, 39, 1'b1);
  endtask

  // fill the store exactly, then close the set on a dropped item
  task automatic test_capacity();
    int base;
    for (int i = 0; i < CAP; i++) begin
      base = $urandom_range(0, 1000000);
      send_interval(base, base + $urandom_range(0, 500), 1'b0);
    end
    send_interval(10, 2, 1'b0);
    send_interval(3, 8, 1'b1);
  endtask

  task automatic test_random(input int unsigned target);
    int unsigned n, style;
    longint b, e, base;
    while (items_sent < target) begin
      n = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(1, 24);
      style = $urandom_range(0, 9);
      base = $signed($urandom);
      no_gaps = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n; i++) begin
        if (style < 6) begin
          b = base + $urandom_range(0, 200);
          e = b + $urandom_range(0, 40);
        end else if (style < 8) begin
          b = $signed($urandom);
          e = $signed($urandom);
          if (b > e && $urandom_range(0, 3) != 0) begin
            base = b;
            b = e;
            e = base;
          end
        end else begin
          case ($urandom_range(0, 3))
            0: b = MIN_POINT;
            1: b = MAX_POINT - $urandom_range(0, 3);
            default: b = $signed($urandom);
          endcase
          e = ($urandom_range(0, 1) == 0) ? MAX_POINT : b + $urandom_range(0, 1000);
        end
        if (style < 6 && $urandom_range(0, 9) == 0) e = b - 1 - $urandom_range(0, 5);
        if (b > MAX_POINT) b = MAX_POINT;
        if (e > MAX_POINT) e = MAX_POINT;
        if (b < MIN_POINT) b = MIN_POINT;
        if (e < MIN_POINT) e = MIN_POINT;
        send_interval(b[31:0], e[31:0], i == n - 1);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    held_count = 0;
    held_overflow = 1'b0;
    mismatches = 0;
    results_seen = 0;
    sets_sent = 0;
    items_sent = 0;
    no_gaps = 1'b0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_capacity();
    test_random(1750);
    start = 1'b0;
    while (union_expect_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (union_expect_q.size() > 0) mismatches++;
    $display("%0d intervals in %0d sets sent, %0d unions checked, incl. full and overfull store",
             items_sent, sets_sent, results_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
